@@ design/cot_pkg.sv @@
// ----------------------------------------------------------------------------
// cot_pkg: shared types and constants for the collider overlap test
// Shape and pair-kind codes, fixed-point widths and the queue entry layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cot_pkg;

  // Shape codes on the type inputs
  localparam logic TYPE_BOX    = 1'b0;
  localparam logic TYPE_CIRCLE = 1'b1;

  // Pair kinds after classification; circle-box pairs always carry the circle as side a
  localparam logic [1:0] KIND_BOX_BOX       = 2'd0;
  localparam logic [1:0] KIND_CIRCLE_CIRCLE = 2'd1;
  localparam logic [1:0] KIND_CIRCLE_BOX    = 2'd2;

  localparam int POS_W   = 24;  // Q15.8 signed position
  localparam int SIZE_W  = 16;  // Q8.8 unsigned size
  localparam int SCALE_W = 8;   // integer scale register
  localparam int SSIZE_W = SIZE_W + SCALE_W;  // scaled size, Q16.8

  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd100;

  localparam int COT_QUEUE_DEPTH = 4;

  // One classified, scaled pair as it sits in the queue
  typedef struct packed {
    logic [1:0]                kind;
    logic signed [POS_W-1:0]   ax;
    logic signed [POS_W-1:0]   ay;
    logic signed [POS_W-1:0]   bx;
    logic signed [POS_W-1:0]   by;
    logic [SSIZE_W-1:0]        asx;
    logic [SSIZE_W-1:0]        asy;
    logic [SSIZE_W-1:0]        bsx;
    logic [SSIZE_W-1:0]        bsy;
  } pair_t;

endpackage

@@ design/cot_queue.sv @@
// ----------------------------------------------------------------------------
// cot_queue: small FIFO between the front and back halves
// Flop-based, one push and one pop per cycle, head read combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cot_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/cot_front.sv @@
// ----------------------------------------------------------------------------
// cot_front: input stage, classification and size scaling
// Holds the scale register, orders circle-box pairs, multiplies sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cot_front (
  input  logic                                clk,
  input  logic                                rst,
  // config write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cot_pkg::SCALE_W-1:0]         cfg_data,
  // input transactions
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                first_type,
  input  logic signed [cot_pkg::POS_W-1:0]    first_x,
  input  logic signed [cot_pkg::POS_W-1:0]    first_y,
  input  logic [cot_pkg::SIZE_W-1:0]          first_width,
  input  logic [cot_pkg::SIZE_W-1:0]          first_height,
  input  logic                                second_type,
  input  logic signed [cot_pkg::POS_W-1:0]    second_x,
  input  logic signed [cot_pkg::POS_W-1:0]    second_y,
  input  logic [cot_pkg::SIZE_W-1:0]          second_width,
  input  logic [cot_pkg::SIZE_W-1:0]          second_height,
  // to queue
  output logic                                push,
  output cot_pkg::pair_t                      push_data,
  input  logic                                queue_full
);

  import cot_pkg::*;

  logic [SCALE_W-1:0] scale;

  // stage 1: classified, ordered, unscaled
  logic                    f1_valid;
  logic [1:0]              f1_kind;
  logic signed [POS_W-1:0] f1_ax, f1_ay, f1_bx, f1_by;
  logic [SIZE_W-1:0]       f1_aw, f1_ah, f1_bw, f1_bh;

  // stage 2: scaled
  logic   f2_valid;
  pair_t  f2_pair;

  logic       front_adv;
  logic       accept;
  logic       swap;
  logic [1:0] kind_next;

  assign cfg_ready = 1'b1;
  assign front_adv = !(f2_valid && queue_full);
  assign in_stall  = !front_adv;
  assign accept    = in_valid && front_adv;
  assign push      = f2_valid && !queue_full;
  assign push_data = f2_pair;

  // circle goes to side a in mixed pairs
  assign swap = (first_type == TYPE_BOX) && (second_type == TYPE_CIRCLE);

  always_comb begin
    if (first_type == TYPE_BOX && second_type == TYPE_BOX) begin
      kind_next = KIND_BOX_BOX;
    end else if (first_type == TYPE_CIRCLE && second_type == TYPE_CIRCLE) begin
      kind_next = KIND_CIRCLE_CIRCLE;
    end else begin
      kind_next = KIND_CIRCLE_BOX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (front_adv) begin
      f1_valid <= accept;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_adv) begin
      f1_kind <= kind_next;
      f1_ax   <= swap ? second_x      : first_x;
      f1_ay   <= swap ? second_y      : first_y;
      f1_aw   <= swap ? second_width  : first_width;
      f1_ah   <= swap ? second_height : first_height;
      f1_bx   <= swap ? first_x       : second_x;
      f1_by   <= swap ? first_y       : second_y;
      f1_bw   <= swap ? first_width   : second_width;
      f1_bh   <= swap ? first_height  : second_height;

      f2_pair.kind <= f1_kind;
      f2_pair.ax   <= f1_ax;
      f2_pair.ay   <= f1_ay;
      f2_pair.bx   <= f1_bx;
      f2_pair.by   <= f1_by;
      f2_pair.asx  <= {{SCALE_W{1'b0}}, f1_aw} * {{SIZE_W{1'b0}}, scale};
      f2_pair.asy  <= {{SCALE_W{1'b0}}, f1_ah} * {{SIZE_W{1'b0}}, scale};
      f2_pair.bsx  <= {{SCALE_W{1'b0}}, f1_bw} * {{SIZE_W{1'b0}}, scale};
      f2_pair.bsy  <= {{SCALE_W{1'b0}}, f1_bh} * {{SIZE_W{1'b0}}, scale};
    end
  end

endmodule

@@ design/cot_back.sv @@
// ----------------------------------------------------------------------------
// cot_back: distance, squaring and compare pipeline
// Three stages; advances whenever the output register is free or drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cot_back (
  input  logic            clk,
  input  logic            rst,
  // from queue
  input  cot_pkg::pair_t  pop_data,
  input  logic            queue_empty,
  output logic            pop,
  // result transactions
  output logic            out_valid,
  input  logic            out_stall,
  output logic            hit
);

  import cot_pkg::*;

  localparam int AW = SSIZE_W + 4;   // signed working width for doubled coordinates
  localparam int DW = SSIZE_W + 2;   // axis distance
  localparam int LW = SSIZE_W + 1;   // limit or radius

  typedef struct packed {
    logic [DW-1:0] d;
    logic [LW-1:0] lim;
  } axis_t;

  // per-axis distance and limit; for circles only the x limit (radius) is used
  function automatic axis_t axis_calc(
    input logic [1:0]               kind,
    input logic signed [POS_W-1:0]  pa,
    input logic signed [POS_W-1:0]  pb,
    input logic [SSIZE_W-1:0]       sa,
    input logic [SSIZE_W-1:0]       sb
  );
    logic signed [AW-1:0] pa2, pb2, sa_w, sb_w, c, hi, diff;
    axis_t r;
    pa2  = {{(AW-POS_W-1){pa[POS_W-1]}}, pa, 1'b0};
    pb2  = {{(AW-POS_W-1){pb[POS_W-1]}}, pb, 1'b0};
    sa_w = {{(AW-SSIZE_W){1'b0}}, sa};
    sb_w = {{(AW-SSIZE_W){1'b0}}, sb};
    c    = pa2 + sa_w;
    hi   = pb2 + {{(AW-SSIZE_W-1){1'b0}}, sb, 1'b0};
    case (kind)
      KIND_CIRCLE_CIRCLE: begin
        diff  = c - (pb2 + sb_w);
        r.lim = {1'b0, sa} + {1'b0, sb};
      end
      KIND_CIRCLE_BOX: begin
        // clamp circle center into the box span
        if (c < pb2) begin
          diff = pb2 - c;
        end else if (c > hi) begin
          diff = c - hi;
        end else begin
          diff = '0;
        end
        r.lim = {1'b0, sa};
      end
      default: begin
        diff  = pa2 - pb2;
        r.lim = {1'b0, sa} + {1'b0, sb};
      end
    endcase
    if (diff < 0) begin
      diff = -diff;
    end
    r.d = diff[DW-1:0];
    return r;
  endfunction

  logic back_adv;

  // stage 1
  logic       b1_valid;
  logic [1:0] b1_kind;
  axis_t      b1_x, b1_y;
  axis_t      ax_next, ay_next;

  // stage 2
  logic             b2_valid;
  logic [1:0]       b2_kind;
  logic             b2_box_hit;
  logic [2*DW-1:0]  b2_dx_sq, b2_dy_sq;
  logic [2*LW-1:0]  b2_r_sq;

  logic [2*DW:0]    dist_sq;
  logic             hit_next;

  assign back_adv = !out_valid || !out_stall;
  assign pop      = back_adv && !queue_empty;

  assign ax_next = axis_calc(pop_data.kind, pop_data.ax, pop_data.bx,
                             pop_data.asx, pop_data.bsx);
  assign ay_next = axis_calc(pop_data.kind, pop_data.ay, pop_data.by,
                             pop_data.asy, pop_data.bsy);

  assign dist_sq  = {1'b0, b2_dx_sq} + {1'b0, b2_dy_sq};
  assign hit_next = (b2_kind == KIND_BOX_BOX) ? b2_box_hit :
                    (dist_sq <= {{(2*DW+1-2*LW){1'b0}}, b2_r_sq});

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (back_adv) begin
      b1_valid  <= !queue_empty;
      b2_valid  <= b1_valid;
      out_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (back_adv) begin
      b1_kind    <= pop_data.kind;
      b1_x       <= ax_next;
      b1_y       <= ay_next;

      b2_kind    <= b1_kind;
      b2_box_hit <= ({1'b0, b1_x.d} < {2'b00, b1_x.lim}) &&
                    ({1'b0, b1_y.d} < {2'b00, b1_y.lim});
      b2_dx_sq   <= b1_x.d * b1_x.d;
      b2_dy_sq   <= b1_y.d * b1_y.d;
      b2_r_sq    <= b1_x.lim * b1_x.lim;

      hit        <= hit_next;
    end
  end

endmodule

@@ design/collider_overlap_test.sv @@
// ----------------------------------------------------------------------------
// collider_overlap_test: 2D box/circle pair overlap test
// Accepted input transactions reach out_valid through the front, queue and back;
//   throughput is one transaction per cycle while in_stall is low.
// Reset: clears all valid flags and the queue, size_scale returns to 100.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Structure:
//   front  - input register, pair classification (box-box, circle-circle,
//            circle-box with the circle moved to side a), then registered
//            16x8 size scaling. Stalls only when its last stage holds a pair
//            and the queue is full.
//   queue  - short flop FIFO that decouples the two halves.
//   back   - axis distances and clamping, then 26x26 squares and the
//            box-box strict compares, then the squared-distance compare into
//            the output register. The whole back pipe holds while a result
//            sits in the output register under out_stall.
// All comparisons are exact: coordinates are doubled so no halving is needed.
// The scale register is written through the cfg channel, always ready.

module collider_overlap_test #(
  parameter int QUEUE_DEPTH = cot_pkg::COT_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cot_pkg::SCALE_W-1:0]         size_scale,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                first_type,
  input  logic signed [cot_pkg::POS_W-1:0]    first_x,
  input  logic signed [cot_pkg::POS_W-1:0]    first_y,
  input  logic [cot_pkg::SIZE_W-1:0]          first_width,
  input  logic [cot_pkg::SIZE_W-1:0]          first_height,
  input  logic                                second_type,
  input  logic signed [cot_pkg::POS_W-1:0]    second_x,
  input  logic signed [cot_pkg::POS_W-1:0]    second_y,
  input  logic [cot_pkg::SIZE_W-1:0]          second_width,
  input  logic [cot_pkg::SIZE_W-1:0]          second_height,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                hit
);

  import cot_pkg::*;

  // front -> queue
  logic   q_push;
  pair_t  q_push_data;
  logic   q_full;

  // queue -> back
  logic   q_pop;
  pair_t  q_pop_data;
  logic   q_empty;

  cot_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (size_scale),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .first_type    (first_type),
    .first_x       (first_x),
    .first_y       (first_y),
    .first_width   (first_width),
    .first_height  (first_height),
    .second_type   (second_type),
    .second_x      (second_x),
    .second_y      (second_y),
    .second_width  (second_width),
    .second_height (second_height),
    .push          (q_push),
    .push_data     (q_push_data),
    .queue_full    (q_full)
  );

  cot_queue #(
    .WIDTH ($bits(pair_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  cot_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_data    (q_pop_data),
    .queue_empty (q_empty),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit)
  );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for collider_overlap_test
// Drives box/circle collider pairs through the valid/stall input channel,
// predicts the overlap flag for every accepted transaction and checks each
// result in order. Walks through several size_scale settings written over
// the config channel while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cot_pkg::*;

  localparam longint POS_MAX   = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN   = -(longint'(1) <<< (POS_W - 1));
  localparam int     CYCLE_CAP = 800000;  // far above the slowest legal run
  localparam int     PHASES    = 7;
  localparam int     PER_PHASE = 150;

  // One collider pair as it appears on the input ports
  typedef struct {
    logic                     t0;
    logic signed [POS_W-1:0]  x0;
    logic signed [POS_W-1:0]  y0;
    logic [SIZE_W-1:0]        w0;
    logic [SIZE_W-1:0]        h0;
    logic                     t1;
    logic signed [POS_W-1:0]  x1;
    logic signed [POS_W-1:0]  y1;
    logic [SIZE_W-1:0]        w1;
    logic [SIZE_W-1:0]        h1;
  } pair_item_t;

  // Clock, reset and all block inputs start at known values
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [SCALE_W-1:0]       size_scale = SCALE_RESET;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     first_type = TYPE_BOX;
  logic signed [POS_W-1:0]  first_x = '0;
  logic signed [POS_W-1:0]  first_y = '0;
  logic [SIZE_W-1:0]        first_width = '0;
  logic [SIZE_W-1:0]        first_height = '0;
  logic                     second_type = TYPE_BOX;
  logic signed [POS_W-1:0]  second_x = '0;
  logic signed [POS_W-1:0]  second_y = '0;
  logic [SIZE_W-1:0]        second_width = '0;
  logic [SIZE_W-1:0]        second_height = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     hit;

  // Bench state
  pair_item_t          pair_queue[$];     // pairs waiting to be driven
  bit                  hit_expected[$];   // predicted hit flags, oldest first
  pair_item_t          pair_on_bus;       // pair currently presented
  logic [SCALE_W-1:0]  scale_now = SCALE_RESET;  // bench copy of the register
  int                  mismatches = 0;
  int                  send_idle = 0;
  int                  send_burst = 0;
  int                  stall_left = 0;
  int                  stall_burst = 0;
  int                  cycle_count = 0;
  bit                  exp_hit;
  logic [SCALE_W-1:0]  phase_scale[PHASES];

  collider_overlap_test u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .size_scale    (size_scale),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .first_type    (first_type),
    .first_x       (first_x),
    .first_y       (first_y),
    .first_width   (first_width),
    .first_height  (first_height),
    .second_type   (second_type),
    .second_x      (second_x),
    .second_y      (second_y),
    .second_width  (second_width),
    .second_height (second_height),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Overlap predictor. Works on doubled coordinates (8 fraction bits) so that
  // circle centers at position plus half size never need a halving; every
  // compare is exact and squared distances stay well inside 64 bits.
  // --------------------------------------------------------------------------
  function automatic longint abs_diff(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Circle (doubled position, scaled size) against a box spanning its
  // position to position plus size on each axis.
  function automatic bit circle_box_hit(longint cpx, longint cpy, longint csx,
                                        longint csy, longint bpx, longint bpy,
                                        longint bsx, longint bsy);
    longint cx, cy, nx, ny, dx, dy;
    cx = cpx + csx;
    cy = cpy + csy;
    nx = (cx < bpx) ? bpx : (cx > bpx + 2 * bsx) ? bpx + 2 * bsx : cx;
    ny = (cy < bpy) ? bpy : (cy > bpy + 2 * bsy) ? bpy + 2 * bsy : cy;
    dx = abs_diff(cx, nx);
    dy = abs_diff(cy, ny);
    // radius is the scaled width only; height just moves the center
    return dx * dx + dy * dy <= csx * csx;
  endfunction

  function automatic bit predict_overlap(pair_item_t p, logic [SCALE_W-1:0] scale);
    longint apx, apy, asx, asy, bpx, bpy, bsx, bsy, dx, dy, rsum;
    apx = 2 * longint'(p.x0);
    apy = 2 * longint'(p.y0);
    bpx = 2 * longint'(p.x1);
    bpy = 2 * longint'(p.y1);
    asx = longint'(p.w0) * longint'(scale);
    asy = longint'(p.h0) * longint'(scale);
    bsx = longint'(p.w1) * longint'(scale);
    bsy = longint'(p.h1) * longint'(scale);
    if (p.t0 == TYPE_BOX && p.t1 == TYPE_BOX) begin
      // centers; strict compare, so touching boxes miss
      dx = abs_diff(apx, bpx);
      dy = abs_diff(apy, bpy);
      return (dx < asx + bsx) && (dy < asy + bsy);
    end
    if (p.t0 == TYPE_CIRCLE && p.t1 == TYPE_CIRCLE) begin
      dx = abs_diff(apx + asx, bpx + bsx);
      dy = abs_diff(apy + asy, bpy + bsy);
      rsum = asx + bsx;
      return dx * dx + dy * dy <= rsum * rsum;
    end
    if (p.t0 == TYPE_CIRCLE)
      return circle_box_hit(apx, apy, asx, asy, bpx, bpy, bsx, bsy);
    return circle_box_hit(bpx, bpy, bsx, bsy, apx, apy, asx, asy);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic pair_item_t mk_pair(logic t0, longint x0, longint y0,
                                         int w0, int h0, logic t1, longint x1,
                                         longint y1, int w1, int h1);
    pair_item_t p;
    p.t0 = t0;  p.x0 = x0[POS_W-1:0];  p.y0 = y0[POS_W-1:0];
    p.w0 = w0[SIZE_W-1:0];  p.h0 = h0[SIZE_W-1:0];
    p.t1 = t1;  p.x1 = x1[POS_W-1:0];  p.y1 = y1[POS_W-1:0];
    p.w1 = w1[SIZE_W-1:0];  p.h1 = h1[SIZE_W-1:0];
    return p;
  endfunction

  function automatic logic signed [POS_W-1:0] fit_pos(longint v);
    if (v > POS_MAX) v = POS_MAX;
    else if (v < POS_MIN) v = POS_MIN;
    return v[POS_W-1:0];
  endfunction

  // Mostly pairs placed near each other with offsets sized from the scaled
  // extents, some right on the contact boundary, some fully random noise.
  function automatic pair_item_t rand_pair(logic [SCALE_W-1:0] scale);
    pair_item_t p;
    int         mode;
    longint     bx, by, spanx, spany, offx, offy;
    mode = $urandom_range(0, 99);
    p.t0 = 1'($urandom);
    p.t1 = 1'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      p.w0 = SIZE_W'($urandom);  p.h0 = SIZE_W'($urandom);
      p.w1 = SIZE_W'($urandom);  p.h1 = SIZE_W'($urandom);
    end else begin
      p.w0 = SIZE_W'($urandom_range(0, 16'h0400));
      p.h0 = SIZE_W'($urandom_range(0, 16'h0400));
      p.w1 = SIZE_W'($urandom_range(0, 16'h0400));
      p.h1 = SIZE_W'($urandom_range(0, 16'h0400));
    end
    if (mode < 15) begin
      p.x0 = POS_W'($urandom);  p.y0 = POS_W'($urandom);
      p.x1 = POS_W'($urandom);  p.y1 = POS_W'($urandom);
      return p;
    end
    bx = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
    by = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
    spanx = (longint'(p.w0) + longint'(p.w1)) * longint'(scale);
    spany = (longint'(p.h0) + longint'(p.h1)) * longint'(scale);
    if (mode < 35) begin
      // right at the contact distance on x, aligned on y
      offx = spanx / 2 + longint'($urandom_range(0, 2)) - 1;
      offy = 0;
      if ($urandom_range(0, 1)) offx = -offx;
    end else begin
      spanx = spanx * 3 / 4 + 2;
      spany = spany * 3 / 4 + 2;
      offx = longint'($urandom_range(0, 32'(2 * spanx))) - spanx;
      offy = longint'($urandom_range(0, 32'(2 * spany))) - spany;
    end
    p.x0 = fit_pos(bx);
    p.y0 = fit_pos(by);
    p.x1 = fit_pos(bx + offx);
    p.y1 = fit_pos(by + offy);
    return p;
  endfunction

  // Idle length: mostly none or short, a few long, with occasional bursts
  // of back-to-back cycles.
  function automatic int next_gap(inout int burst_left);
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: the payload only moves when the bus is empty or the
  // current transaction has just been taken. The prediction is made at the
  // accepting edge with the register value in force.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hit_expected.push_back(predict_overlap(pair_on_bus, scale_now));
        send_idle = next_gap(send_burst);
      end
      if (!in_valid || !in_stall) begin
        if (send_idle > 0 || pair_queue.size() == 0) begin
          if (send_idle > 0) send_idle--;
          in_valid <= 1'b0;
        end else begin
          pair_on_bus = pair_queue.pop_front();
          first_type    <= pair_on_bus.t0;
          first_x       <= pair_on_bus.x0;
          first_y       <= pair_on_bus.y0;
          first_width   <= pair_on_bus.w0;
          first_height  <= pair_on_bus.h0;
          second_type   <= pair_on_bus.t1;
          second_x      <= pair_on_bus.x1;
          second_y      <= pair_on_bus.y1;
          second_width  <= pair_on_bus.w1;
          second_height <= pair_on_bus.h1;
          in_valid      <= 1'b1;
        end
      end
    end
  end

  // Output back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = next_gap(stall_burst);
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: every accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (hit_expected.size() == 0) begin
        $error("hit: result with no transaction outstanding, actual %0b", hit);
        mismatches++;
      end else begin
        exp_hit = hit_expected.pop_front();
        if (hit !== exp_hit) begin
          $error("hit: expected %0b, actual %0b", exp_hit, hit);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  // Returns at a falling edge once nothing is queued, on the bus or in flight.
  task automatic wait_drained();
    @(negedge clk);
    while (pair_queue.size() != 0 || in_valid || hit_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] value);
    @(posedge clk);
    cfg_valid  <= 1'b1;
    size_scale <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scale_now = value;
    @(negedge clk);
  endtask

  initial begin
    phase_scale[0] = 8'd1;
    phase_scale[1] = 8'd255;
    phase_scale[2] = 8'd0;      // outside the documented range, still legal
    phase_scale[3] = SCALE_W'($urandom_range(2, 254));
    phase_scale[4] = SCALE_W'($urandom_range(2, 254));
    phase_scale[5] = SCALE_RESET;
    phase_scale[6] = SCALE_W'($urandom_range(2, 254));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed pairs at the reset scale of 100: a 1.0 size scales to 25600,
    // so raw offsets of 25600 put the shapes exactly in contact.
    // boxes: overlapping, touching on x, just inside, touching on y, zero size
    pair_queue.push_back(mk_pair(TYPE_BOX, 0, 0, 'h100, 'h100, TYPE_BOX, 0, 0, 'h100, 'h100));
    pair_queue.push_back(mk_pair(TYPE_BOX, 0, 0, 'h100, 'h100, TYPE_BOX, 25600, 0, 'h100, 'h100));
    pair_queue.push_back(mk_pair(TYPE_BOX, 0, 0, 'h100, 'h100, TYPE_BOX, 25599, 0, 'h100, 'h100));
    pair_queue.push_back(mk_pair(TYPE_BOX, 0, 0, 'h100, 'h100, TYPE_BOX, 0, 25600, 'h100, 'h100));
    pair_queue.push_back(mk_pair(TYPE_BOX, 5, 5, 0, 0, TYPE_BOX, 5, 5, 0, 0));
    // circles: touching hits, one step further misses
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, 0, 0, 'h100, 'h100,
                                 TYPE_CIRCLE, 25600, 0, 'h100, 'h100));
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, 0, 0, 'h100, 'h100,
                                 TYPE_CIRCLE, 25601, 0, 'h100, 'h100));
    // circle against box, both orders, touching and just apart
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, 0, 0, 'h100, 'h100,
                                 TYPE_BOX, 25600, 0, 'h100, 'h100));
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, 0, 0, 'h100, 'h100,
                                 TYPE_BOX, 25601, 0, 'h100, 'h100));
    pair_queue.push_back(mk_pair(TYPE_BOX, 25600, 0, 'h100, 'h100,
                                 TYPE_CIRCLE, 0, 0, 'h100, 'h100));
    // near a box corner: diagonal distance decides
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, 0, 0, 'h100, 'h100,
                                 TYPE_BOX, 21850, 21850, 'h100, 'h100));
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, 0, 0, 'h100, 'h100,
                                 TYPE_BOX, 25600, 25600, 'h100, 'h100));
    // circle height only shifts the center, radius stays width based
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, 0, 0, 'h100, 'h400,
                                 TYPE_CIRCLE, 0, 0, 'h100, 'h100));
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, 0, 0, 'h100, 'h100,
                                 TYPE_CIRCLE, 0, 0, 'h100, 'h100));
    // zero radius circles: only exact contact counts
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, 0, 0, 0, 0, TYPE_BOX, 0, 0, 'h100, 'h100));
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, -7, 9, 0, 0, TYPE_CIRCLE, -7, 9, 0, 0));
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, -7, 9, 0, 0, TYPE_CIRCLE, -6, 9, 0, 0));
    // field extremes: opposite corners of the position range, full sizes
    pair_queue.push_back(mk_pair(TYPE_BOX, POS_MAX, POS_MAX, 'hFFFF, 'hFFFF,
                                 TYPE_BOX, POS_MIN, POS_MIN, 'hFFFF, 'hFFFF));
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, POS_MAX, POS_MAX, 'hFFFF, 'hFFFF,
                                 TYPE_CIRCLE, POS_MAX, POS_MAX, 'hFFFF, 'hFFFF));
    pair_queue.push_back(mk_pair(TYPE_CIRCLE, POS_MIN, POS_MIN, 'hFFFF, 'hFFFF,
                                 TYPE_BOX, POS_MAX, POS_MIN, 'hFFFF, 0));
    pair_queue.push_back(mk_pair(TYPE_BOX, POS_MIN, POS_MAX, 'hFFFF, 'hFFFF,
                                 TYPE_CIRCLE, POS_MIN, POS_MAX, 'hFFFF, 'hFFFF));
    pair_queue.push_back(mk_pair(TYPE_BOX, -25600, -100, 'h100, 'h80,
                                 TYPE_BOX, -100, -25600, 'h80, 'h100));
    wait_drained();

    // Random phases, one register setting each, written only when drained
    for (int ph = 0; ph < PHASES; ph++) begin
      write_scale(phase_scale[ph]);
      for (int i = 0; i < PER_PHASE; i++)
        pair_queue.push_back(rand_pair(phase_scale[ph]));
      wait_drained();
    end

    // let any stray result surface before judging
    repeat (20) @(posedge clk);
    if (hit_expected.size() != 0) begin
      $error("hit: %0d predicted results never arrived", hit_expected.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
